// File: sv/lgtr_pkg.sv
// ----------------------------------------------------------------------------
// lgtr_pkg
// shared types and constants of the lda gibbs topic resampler
// ----------------------------------------------------------------------------
package lgtr_pkg;

    localparam int DOC_W   = 10;
    localparam int WORD_W  = 12;
    localparam int TIDX_W  = 4;
    localparam int VAL_W   = 16;
    localparam int FUNC_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int VOC_W   = 13;
    localparam int ACT_W   = 5;
    localparam int TW_W    = 32;
    localparam int DT_W    = 16;
    localparam int SCORE_W = 32;
    localparam int LEFT_W  = 33;
    localparam int RIGHT_W = 27;
    localparam int VB_W    = 29;
    localparam int NUM_W   = 60;
    localparam int DEN_W   = 33;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_ALPHA = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_TOKEN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESAMPLE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BETA_PRIOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOCAB_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TOPIC = 2'd2;

    localparam logic [VAL_W-1:0] BETA_RESET   = 16'd10;
    localparam logic [VOC_W-1:0] VOCAB_RESET  = 13'd4096;
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CHG_RD,
        ST_CHG_WR,
        ST_SC_RD,
        ST_SC_MUL0,
        ST_SC_MUL1,
        ST_SC_MUL2,
        ST_SC_DIV0,
        ST_SC_DIV,
        ST_SC_STORE,
        ST_LIMIT,
        ST_PICK,
        ST_OUT
    } state_t;

endpackage

// File: sv/lgtr_ram.sv
// ----------------------------------------------------------------------------
// lgtr_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module lgtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lgtr_divider.sv
// ----------------------------------------------------------------------------
// lgtr_divider
// restoring divider, one quotient bit per cycle, saturating 32 bit quotient
// of num * 64 / den, zero when den is zero
// ----------------------------------------------------------------------------
module lgtr_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lgtr_pkg::NUM_W-1:0]        num,
    input  logic [lgtr_pkg::DEN_W-1:0]        den,
    output logic                              done,
    output logic [lgtr_pkg::SCORE_W-1:0]      quot
);

    localparam int EXT_W = lgtr_pkg::NUM_W + 6;
    localparam int HI_W  = EXT_W - lgtr_pkg::SCORE_W;
    localparam int CNT_W = $clog2(lgtr_pkg::SCORE_W);

    logic [EXT_W-1:0]                 n_ext;
    logic [HI_W-1:0]                  n_hi;
    logic                             den_zero;
    logic                             too_big;
    logic [lgtr_pkg::DEN_W:0]         rem_shift;
    logic                             ge;
    logic [lgtr_pkg::DEN_W-1:0]       rem_next;

    logic                             busy_reg;
    logic                             done_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [lgtr_pkg::DEN_W-1:0]       rem_reg;
    logic [lgtr_pkg::SCORE_W-1:0]     low_reg;
    logic [lgtr_pkg::DEN_W-1:0]       den_reg;
    logic [lgtr_pkg::SCORE_W-1:0]     quot_reg;

    always_comb
    begin
        n_ext     = {num, 6'b0};
        n_hi      = n_ext[EXT_W-1:lgtr_pkg::SCORE_W];
        den_zero  = (den == '0);
        too_big   = (n_hi >= HI_W'(den));
        rem_shift = {rem_reg, low_reg[lgtr_pkg::SCORE_W-1]};
        ge        = (rem_shift >= {1'b0, den_reg});
        rem_next  = ge ? lgtr_pkg::DEN_W'(rem_shift - {1'b0, den_reg})
                       : lgtr_pkg::DEN_W'(rem_shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !(den_zero || too_big);
                done_reg <= den_zero || too_big;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(lgtr_pkg::SCORE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= n_hi[lgtr_pkg::DEN_W-1:0];
            low_reg  <= n_ext[lgtr_pkg::SCORE_W-1:0];
            den_reg  <= den;
            quot_reg <= den_zero ? '0 : '1;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[lgtr_pkg::SCORE_W-2:0], ge};
            if (cnt_reg == CNT_W'(lgtr_pkg::SCORE_W - 1))
            begin
                quot_reg <= {low_reg[lgtr_pkg::SCORE_W-2:0], ge};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: sv/lda_gibbs_topic_resampler.sv
// ----------------------------------------------------------------------------
// lda_gibbs_topic_resampler
// weighted collapsed gibbs topic resampling over ram based count stores
// ----------------------------------------------------------------------------
// input stream: tuser carries the item kind (load alpha, add token, resample),
// tdata the token fields. output stream: one new topic per in-range resample.
// config port: beta prior, vocabulary size and active topic count, to be
// written only while the block is idle; the block does not enforce this.
// after reset both count rams are swept to zero, one entry per cycle, over
// max(TOPICS*VOCAB, DOCS*TOPICS) entries (65536 by default); s_axis_tready
// stays low during the sweep, config writes are taken.
// one item at a time. load alpha and ignored items end after decode; add
// token also reads and writes the counts. resample removes the token, scores
// each of the K active topics, walks them in the pick and adds the token back;
// each topic: a two part multiply, a 32 step bit serial divide that sets the rate.
// a finished topic sits in the output register; the next item is accepted
// meanwhile, and a resample that finishes while the receiver still stalls
// waits in its last state until the register frees up.
// ----------------------------------------------------------------------------
module lda_gibbs_topic_resampler #(
    parameter int TOPICS = 16,
    parameter int VOCAB  = 4096,
    parameter int DOCS   = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // doc_index, word_index, topic_index, word_weight, alpha_value,
    // random_draw, zero fill
    input  logic [79:0] s_axis_tdata,
    // func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_topic, zero fill
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int TOPIC_W   = $clog2(TOPICS);
    localparam int KW        = TOPIC_W + 1;
    localparam int SUM_W     = lgtr_pkg::SCORE_W + TOPIC_W;
    localparam int LP_W      = SUM_W + 16;
    localparam int TW_DEPTH  = TOPICS * VOCAB;
    localparam int DT_DEPTH  = DOCS * TOPICS;
    localparam int TW_AW     = $clog2(TW_DEPTH);
    localparam int DT_AW     = $clog2(DT_DEPTH);
    localparam int CLR_DEPTH = (TW_DEPTH > DT_DEPTH) ? TW_DEPTH : DT_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);

    lgtr_pkg::state_t state_reg, state_next;

    logic [CLR_W-1:0]                  clr_cnt_reg;
    logic [lgtr_pkg::VAL_W-1:0]        beta_reg;
    logic [lgtr_pkg::VOC_W-1:0]        vocab_reg;
    logic [lgtr_pkg::ACT_W-1:0]        active_reg;
    logic                              out_valid_reg;
    logic [lgtr_pkg::TIDX_W-1:0]       out_topic_reg;
    logic [lgtr_pkg::TW_W-1:0]         total_reg [TOPICS];

    logic [lgtr_pkg::FUNC_W-1:0]       func_reg;
    logic [lgtr_pkg::DOC_W-1:0]        doc_reg;
    logic [lgtr_pkg::WORD_W-1:0]       word_reg;
    logic [lgtr_pkg::TIDX_W-1:0]       tin_reg;
    logic [lgtr_pkg::VAL_W-1:0]        weight_reg;
    logic [lgtr_pkg::VAL_W-1:0]        alpha_in_reg;
    logic [lgtr_pkg::VAL_W-1:0]        draw_reg;
    logic [lgtr_pkg::VB_W-1:0]         vb_reg;
    logic [TOPIC_W-1:0]                chg_topic_reg;
    logic                              chg_add_reg;
    logic [TOPIC_W-1:0]                k_reg;
    logic [lgtr_pkg::LEFT_W-1:0]       left_reg;
    logic [lgtr_pkg::RIGHT_W-1:0]      right_reg;
    logic [lgtr_pkg::DEN_W-1:0]        den_reg;
    logic [42:0]                       prod_lo_reg;
    logic [43:0]                       prod_hi_reg;
    logic [SUM_W-1:0]                  sum_reg;
    logic [SUM_W-1:0]                  limit_reg;
    logic [SUM_W-1:0]                  run_reg;
    logic [lgtr_pkg::VAL_W-1:0]        alpha_reg [TOPICS];
    logic [lgtr_pkg::SCORE_W-1:0]      score_reg [TOPICS];

    logic [KW-1:0]                     kmax;
    logic                              in_range;
    logic                              k_last;
    logic                              in_accept;
    logic                              out_load;
    logic [TW_AW-1:0]                  chg_tw_addr;
    logic [DT_AW-1:0]                  chg_dt_addr;
    logic [TW_AW-1:0]                  sc_tw_addr;
    logic [DT_AW-1:0]                  sc_dt_addr;
    logic [lgtr_pkg::TW_W:0]           tw_sum;
    logic [lgtr_pkg::TW_W-1:0]         tw_mod;
    logic [lgtr_pkg::TW_W:0]           tot_sum;
    logic [lgtr_pkg::TW_W-1:0]         tot_mod;
    logic [lgtr_pkg::DT_W-1:0]         dt_mod;
    logic [SUM_W-1:0]                  run_next;
    logic                              run_hit;
    logic [LP_W-1:0]                   lim_prod;
    logic [lgtr_pkg::NUM_W-1:0]        div_num;

    logic                              tw_we;
    logic [TW_AW-1:0]                  tw_addr;
    logic [lgtr_pkg::TW_W-1:0]         tw_wdata;
    logic [lgtr_pkg::TW_W-1:0]         tw_rdata;
    logic                              dt_we;
    logic [DT_AW-1:0]                  dt_addr;
    logic [lgtr_pkg::DT_W-1:0]         dt_wdata;
    logic [lgtr_pkg::DT_W-1:0]         dt_rdata;
    logic                              div_start;
    logic                              div_done;
    logic [lgtr_pkg::SCORE_W-1:0]      div_quot;

    lgtr_ram #(
        .WIDTH (lgtr_pkg::TW_W),
        .DEPTH (TW_DEPTH)
    ) u_topic_word_ram (
        .clk   (clk),
        .we    (tw_we),
        .addr  (tw_addr),
        .wdata (tw_wdata),
        .rdata (tw_rdata)
    );

    lgtr_ram #(
        .WIDTH (lgtr_pkg::DT_W),
        .DEPTH (DT_DEPTH)
    ) u_doc_topic_ram (
        .clk   (clk),
        .we    (dt_we),
        .addr  (dt_addr),
        .wdata (dt_wdata),
        .rdata (dt_rdata)
    );

    lgtr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // shared datapath terms
    always_comb
    begin
        if (active_reg == '0)
        begin
            kmax = KW'(1);
        end
        else if (32'(active_reg) > TOPICS)
        begin
            kmax = KW'(TOPICS);
        end
        else
        begin
            kmax = KW'(active_reg);
        end
        in_range = (32'(tin_reg) < 32'(kmax)) && (32'(word_reg) < VOCAB)
                   && (32'(doc_reg) < DOCS);
        k_last   = (KW'(k_reg) == (kmax - KW'(1)));
        in_accept = s_axis_tvalid && s_axis_tready;
        out_load  = !out_valid_reg || m_axis_tready;

        chg_tw_addr = TW_AW'(32'(chg_topic_reg) * VOCAB + 32'(word_reg));
        chg_dt_addr = DT_AW'(32'(doc_reg) * TOPICS + 32'(chg_topic_reg));
        sc_tw_addr  = TW_AW'(32'(k_reg) * VOCAB + 32'(word_reg));
        sc_dt_addr  = DT_AW'(32'(doc_reg) * TOPICS + 32'(k_reg));

        tw_sum  = {1'b0, tw_rdata} + (lgtr_pkg::TW_W + 1)'(weight_reg);
        tot_sum = {1'b0, total_reg[chg_topic_reg]} + (lgtr_pkg::TW_W + 1)'(weight_reg);
        if (chg_add_reg)
        begin
            tw_mod  = tw_sum[lgtr_pkg::TW_W] ? '1 : tw_sum[lgtr_pkg::TW_W-1:0];
            tot_mod = tot_sum[lgtr_pkg::TW_W] ? '1 : tot_sum[lgtr_pkg::TW_W-1:0];
            dt_mod  = (dt_rdata == '1) ? dt_rdata : dt_rdata + lgtr_pkg::DT_W'(1);
        end
        else
        begin
            tw_mod  = (tw_rdata > lgtr_pkg::TW_W'(weight_reg))
                      ? tw_rdata - lgtr_pkg::TW_W'(weight_reg) : '0;
            tot_mod = (total_reg[chg_topic_reg] > lgtr_pkg::TW_W'(weight_reg))
                      ? total_reg[chg_topic_reg] - lgtr_pkg::TW_W'(weight_reg) : '0;
            dt_mod  = (dt_rdata == '0) ? dt_rdata : dt_rdata - lgtr_pkg::DT_W'(1);
        end

        run_next = run_reg + SUM_W'(score_reg[k_reg]);
        run_hit  = (run_next > limit_reg);
        lim_prod = LP_W'(sum_reg) * LP_W'(draw_reg);
        div_num  = lgtr_pkg::NUM_W'(prod_lo_reg) + {prod_hi_reg, 16'b0};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgtr_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = lgtr_pkg::ST_IDLE;
                end
            end
            lgtr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = lgtr_pkg::ST_DECODE;
                end
            end
            lgtr_pkg::ST_DECODE:
            begin
                if ((func_reg == lgtr_pkg::FUNC_ADD_TOKEN
                     || func_reg == lgtr_pkg::FUNC_RESAMPLE) && in_range)
                begin
                    state_next = lgtr_pkg::ST_CHG_RD;
                end
                else
                begin
                    state_next = lgtr_pkg::ST_IDLE;
                end
            end
            lgtr_pkg::ST_CHG_RD:
            begin
                state_next = lgtr_pkg::ST_CHG_WR;
            end
            lgtr_pkg::ST_CHG_WR:
            begin
                if (func_reg != lgtr_pkg::FUNC_RESAMPLE)
                begin
                    state_next = lgtr_pkg::ST_IDLE;
                end
                else if (chg_add_reg)
                begin
                    state_next = lgtr_pkg::ST_OUT;
                end
                else
                begin
                    state_next = lgtr_pkg::ST_SC_RD;
                end
            end
            lgtr_pkg::ST_SC_RD:
            begin
                state_next = lgtr_pkg::ST_SC_MUL0;
            end
            lgtr_pkg::ST_SC_MUL0:
            begin
                state_next = lgtr_pkg::ST_SC_MUL1;
            end
            lgtr_pkg::ST_SC_MUL1:
            begin
                state_next = lgtr_pkg::ST_SC_MUL2;
            end
            lgtr_pkg::ST_SC_MUL2:
            begin
                state_next = lgtr_pkg::ST_SC_DIV0;
            end
            lgtr_pkg::ST_SC_DIV0:
            begin
                state_next = lgtr_pkg::ST_SC_DIV;
            end
            lgtr_pkg::ST_SC_DIV:
            begin
                if (div_done)
                begin
                    state_next = lgtr_pkg::ST_SC_STORE;
                end
            end
            lgtr_pkg::ST_SC_STORE:
            begin
                state_next = k_last ? lgtr_pkg::ST_LIMIT : lgtr_pkg::ST_SC_RD;
            end
            lgtr_pkg::ST_LIMIT:
            begin
                state_next = lgtr_pkg::ST_PICK;
            end
            lgtr_pkg::ST_PICK:
            begin
                if (run_hit || k_last)
                begin
                    state_next = lgtr_pkg::ST_CHG_RD;
                end
            end
            lgtr_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = lgtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lgtr_pkg::ST_IDLE;
            end
        endcase
    end

    // ram and handshake controls
    always_comb
    begin
        s_axis_tready = 1'b0;
        tw_we         = 1'b0;
        tw_addr       = chg_tw_addr;
        tw_wdata      = tw_mod;
        dt_we         = 1'b0;
        dt_addr       = chg_dt_addr;
        dt_wdata      = dt_mod;
        div_start     = 1'b0;
        case (state_reg)
            lgtr_pkg::ST_CLEAR:
            begin
                tw_addr  = clr_cnt_reg[TW_AW-1:0];
                tw_wdata = '0;
                tw_we    = (32'(clr_cnt_reg) < TW_DEPTH);
                dt_addr  = clr_cnt_reg[DT_AW-1:0];
                dt_wdata = '0;
                dt_we    = (32'(clr_cnt_reg) < DT_DEPTH);
            end
            lgtr_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            lgtr_pkg::ST_CHG_WR:
            begin
                tw_we = 1'b1;
                dt_we = 1'b1;
            end
            lgtr_pkg::ST_SC_RD:
            begin
                tw_addr = sc_tw_addr;
                dt_addr = sc_dt_addr;
            end
            lgtr_pkg::ST_SC_DIV0:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgtr_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            beta_reg      <= lgtr_pkg::BETA_RESET;
            vocab_reg     <= lgtr_pkg::VOCAB_RESET;
            active_reg    <= lgtr_pkg::ACTIVE_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TOPICS; i++)
            begin
                total_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lgtr_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lgtr_pkg::REG_BETA_PRIOR:   beta_reg   <= cfg_wdata;
                    lgtr_pkg::REG_VOCAB_SIZE:   vocab_reg  <= cfg_wdata[lgtr_pkg::VOC_W-1:0];
                    lgtr_pkg::REG_ACTIVE_TOPIC: active_reg <= cfg_wdata[lgtr_pkg::ACT_W-1:0];
                    default:                    beta_reg   <= beta_reg;
                endcase
            end
            if (state_reg == lgtr_pkg::ST_CHG_WR)
            begin
                total_reg[chg_topic_reg] <= tot_mod;
            end
            if (state_reg == lgtr_pkg::ST_OUT && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg     <= s_axis_tuser;
            doc_reg      <= s_axis_tdata[9:0];
            word_reg     <= s_axis_tdata[21:10];
            tin_reg      <= s_axis_tdata[25:22];
            weight_reg   <= s_axis_tdata[41:26];
            alpha_in_reg <= s_axis_tdata[57:42];
            draw_reg     <= s_axis_tdata[73:58];
        end
        case (state_reg)
            lgtr_pkg::ST_DECODE:
            begin
                vb_reg        <= lgtr_pkg::VB_W'(vocab_reg * beta_reg);
                chg_topic_reg <= TOPIC_W'(tin_reg);
                chg_add_reg   <= (func_reg == lgtr_pkg::FUNC_ADD_TOKEN);
                if (func_reg == lgtr_pkg::FUNC_LOAD_ALPHA && 32'(tin_reg) < TOPICS)
                begin
                    alpha_reg[TOPIC_W'(tin_reg)] <= alpha_in_reg;
                end
            end
            lgtr_pkg::ST_CHG_WR:
            begin
                k_reg   <= '0;
                sum_reg <= '0;
            end
            lgtr_pkg::ST_SC_MUL0:
            begin
                left_reg  <= lgtr_pkg::LEFT_W'(beta_reg) + lgtr_pkg::LEFT_W'(tw_rdata);
                right_reg <= {1'b0, dt_rdata, 10'b0}
                             + lgtr_pkg::RIGHT_W'(alpha_reg[k_reg]);
                den_reg   <= lgtr_pkg::DEN_W'(vb_reg) + lgtr_pkg::DEN_W'(total_reg[k_reg]);
            end
            lgtr_pkg::ST_SC_MUL1:
            begin
                prod_lo_reg <= 43'(left_reg[15:0]) * 43'(right_reg);
            end
            lgtr_pkg::ST_SC_MUL2:
            begin
                prod_hi_reg <= 44'(left_reg[32:16]) * 44'(right_reg);
            end
            lgtr_pkg::ST_SC_STORE:
            begin
                score_reg[k_reg] <= div_quot;
                sum_reg          <= sum_reg + SUM_W'(div_quot);
                k_reg            <= k_reg + TOPIC_W'(1);
            end
            lgtr_pkg::ST_LIMIT:
            begin
                limit_reg <= lim_prod[LP_W-1:16];
                k_reg     <= '0;
                run_reg   <= '0;
            end
            lgtr_pkg::ST_PICK:
            begin
                run_reg <= run_next;
                k_reg   <= k_reg + TOPIC_W'(1);
                if (run_hit || k_last)
                begin
                    chg_topic_reg <= k_reg;
                    chg_add_reg   <= 1'b1;
                end
            end
            lgtr_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_topic_reg <= lgtr_pkg::TIDX_W'(chg_topic_reg);
                end
            end
            default:
            begin
                vb_reg <= vb_reg;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_topic_reg};

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lgtr_pkg::ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during ram sweep");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == lgtr_pkg::ST_SC_DIV))
        else $error("divider finished outside its wait state");

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == lgtr_pkg::ST_OUT))
        else $error("result shown without a finished resample");

    a_ram_write_only_when_owned: assert property (@(posedge clk) disable iff (!rst_n)
        tw_we |-> (state_reg == lgtr_pkg::ST_CLEAR || state_reg == lgtr_pkg::ST_CHG_WR))
        else $error("topic word ram written outside sweep or update");
`endif

endmodule

// File: test/tb_lda_gibbs_topic_resampler.sv
// ----------------------------------------------------------------------------
// tb_lda_gibbs_topic_resampler
// self-checking testbench of the lda gibbs topic resampler: a directed table
// of token transactions is followed by random load alpha, add, resample and unused sequences
// under several register settings and idle patterns; each new topic is
// checked against a cycle-free prediction of the count stores and scores
// ----------------------------------------------------------------------------
module tb_lda_gibbs_topic_resampler;

    localparam logic [lgtr_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int NTOPIC = 16;
    localparam int NVOCAB = 4096;
    localparam int NDOC = 1024;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int ITEMS_PER_PHASE = 140;

    typedef struct packed {
        logic [lgtr_pkg::FUNC_W-1:0] func;
        logic [lgtr_pkg::DOC_W-1:0]  doc;
        logic [lgtr_pkg::WORD_W-1:0] word;
        logic [lgtr_pkg::TIDX_W-1:0] topic;
        logic [lgtr_pkg::VAL_W-1:0]  weight;
        logic [lgtr_pkg::VAL_W-1:0]  alpha;
        logic [lgtr_pkg::VAL_W-1:0]  draw;
    } token_t;

    typedef struct packed {
        token_t                      tok;
        logic                        typed;
        logic                        exp_has;
        logic [lgtr_pkg::TIDX_W-1:0] exp_topic;
    } row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    lda_gibbs_topic_resampler DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // model of the count stores
    bit [31:0] word_weight_mem [NTOPIC*NVOCAB];
    bit [15:0] doc_count_mem [NDOC*NTOPIC];
    bit [31:0] topic_total [NTOPIC];
    bit [15:0] alpha_mem [NTOPIC];
    bit [15:0] beta_reg = lgtr_pkg::BETA_RESET;
    bit [12:0] vocab_reg = lgtr_pkg::VOCAB_RESET;
    bit [4:0]  active_reg = lgtr_pkg::ACTIVE_RESET;

    logic [lgtr_pkg::TIDX_W-1:0] pending_topics [$];
    int  errors = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  quiet_cycles = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int live_count();
        int k;
        k = int'(active_reg);
        if (k < 1) k = 1;
        if (k > NTOPIC) k = NTOPIC;
        return k;
    endfunction

    function automatic void update_counts(int d, int w, int t, bit [31:0] wt, bit add);
        int iw;
        int id;
        longint unsigned s;
        iw = t * NVOCAB + w;
        id = d * NTOPIC + t;
        if (add)
        begin
            s = longint'(word_weight_mem[iw]) + wt;
            word_weight_mem[iw] = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
            s = longint'(topic_total[t]) + wt;
            topic_total[t] = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
            if (doc_count_mem[id] != 16'hFFFF) doc_count_mem[id]++;
        end
        else
        begin
            word_weight_mem[iw] = (word_weight_mem[iw] > wt) ? word_weight_mem[iw] - wt
                                                               : 32'd0;
            topic_total[t] = (topic_total[t] > wt) ? topic_total[t] - wt : 32'd0;
            if (doc_count_mem[id] != 0) doc_count_mem[id]--;
        end
    endfunction

    function automatic longint unsigned topic_score(int d, int w, int k);
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint unsigned r;
        longint unsigned s;
        lhs = longint'(beta_reg) + word_weight_mem[k*NVOCAB + w];
        rhs = (longint'(doc_count_mem[d*NTOPIC + k]) << 10) + alpha_mem[k];
        num = lhs * rhs;
        den = longint'(vocab_reg) * beta_reg + topic_total[k];
        if (den == 0) return 0;
        q = num / den;
        r = num % den;
        if (q >= (64'd1 << 26)) return 64'hFFFFFFFF;
        s = (q << 6) + ((r << 6) / den);
        return (s > 64'hFFFFFFFF) ? 64'hFFFFFFFF : s;
    endfunction

    // applies one transaction to the model, returns whether a topic comes out
    function automatic bit resample_predict(token_t tk,
                                            output logic [lgtr_pkg::TIDX_W-1:0] pick);
        int kmax;
        int k;
        int sel;
        longint unsigned scores [NTOPIC];
        longint unsigned sum;
        longint unsigned lim;
        longint unsigned run;
        kmax = live_count();
        pick = '0;
        if (tk.func == lgtr_pkg::FUNC_LOAD_ALPHA)
        begin
            alpha_mem[tk.topic] = tk.alpha;
            return 0;
        end
        if (tk.func == FUNC_UNUSED || int'(tk.topic) >= kmax) return 0;
        if (tk.func == lgtr_pkg::FUNC_ADD_TOKEN)
        begin
            update_counts(int'(tk.doc), int'(tk.word), int'(tk.topic), 32'(tk.weight), 1);
            return 0;
        end
        update_counts(int'(tk.doc), int'(tk.word), int'(tk.topic), 32'(tk.weight), 0);
        sum = 0;
        for (k = 0; k < kmax; k++)
        begin
            scores[k] = topic_score(int'(tk.doc), int'(tk.word), k);
            sum += scores[k];
        end
        lim = (sum * tk.draw) >> 16;
        sel = kmax - 1;
        run = 0;
        for (k = 0; k < kmax; k++)
        begin
            run += scores[k];
            if (run > lim)
            begin
                sel = k;
                break;
            end
        end
        update_counts(int'(tk.doc), int'(tk.word), sel, 32'(tk.weight), 1);
        pick = lgtr_pkg::TIDX_W'(sel);
        return 1;
    endfunction

    task automatic send_token(row_t rw);
        logic [lgtr_pkg::TIDX_W-1:0] pick;
        bit has;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rw.tok.func;
        s_axis_tdata <= {6'd0, rw.tok.draw, rw.tok.alpha, rw.tok.weight,
                         rw.tok.topic, rw.tok.word, rw.tok.doc};
        do @(posedge clk); while (!s_axis_tready);
        has = resample_predict(rw.tok, pick);
        if (rw.typed)
        begin
            has = rw.exp_has;
            pick = rw.exp_topic;
        end
        if (has) pending_topics = {pending_topics, pick};
    endtask

    task automatic write_regs(bit [15:0] beta, bit [12:0] vocab, bit [4:0] active);
        cfg_wr_en <= 1'b1;
        cfg_index <= lgtr_pkg::REG_BETA_PRIOR;
        cfg_wdata <= beta;
        @(posedge clk);
        cfg_index <= lgtr_pkg::REG_VOCAB_SIZE;
        cfg_wdata <= 16'(vocab);
        @(posedge clk);
        cfg_index <= lgtr_pkg::REG_ACTIVE_TOPIC;
        cfg_wdata <= 16'(active);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        beta_reg = beta;
        vocab_reg = vocab;
        active_reg = active;
    endtask

    task automatic drain();
        while (pending_topics.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic row_t mk_row(logic [1:0] f, int d, int w, int t, int wt, int av,
                                    int dr, bit typed, bit has, int tp);
        row_t rw;
        rw.tok.func = f;
        rw.tok.doc = lgtr_pkg::DOC_W'(d);
        rw.tok.word = lgtr_pkg::WORD_W'(w);
        rw.tok.topic = lgtr_pkg::TIDX_W'(t);
        rw.tok.weight = lgtr_pkg::VAL_W'(wt);
        rw.tok.alpha = lgtr_pkg::VAL_W'(av);
        rw.tok.draw = lgtr_pkg::VAL_W'(dr);
        rw.typed = typed;
        rw.exp_has = has;
        rw.exp_topic = lgtr_pkg::TIDX_W'(tp);
        return rw;
    endfunction

    function automatic row_t random_row();
        row_t rw;
        int sel;
        rw = '0;
        sel = $urandom_range(99);
        rw.tok.doc = lgtr_pkg::DOC_W'(($urandom_range(99) < 80) ? $urandom_range(3)
                                                               : $urandom_range(NDOC-1));
        rw.tok.word = lgtr_pkg::WORD_W'(($urandom_range(99) < 80) ? $urandom_range(7)
                                                                 : $urandom_range(NVOCAB-1));
        rw.tok.topic = lgtr_pkg::TIDX_W'(($urandom_range(99) < 85)
                                         ? $urandom_range(live_count()-1)
                                         : $urandom_range(NTOPIC-1));
        rw.tok.weight = lgtr_pkg::VAL_W'(($urandom_range(99) < 10) ? 16'hFFFF
                                                                  : $urandom_range(16'hFFFF));
        rw.tok.alpha = lgtr_pkg::VAL_W'($urandom_range(16'hFFFF));
        rw.tok.draw = lgtr_pkg::VAL_W'($urandom_range(16'hFFFF));
        if (sel < 8) rw.tok.func = lgtr_pkg::FUNC_LOAD_ALPHA;
        else if (sel < 45) rw.tok.func = lgtr_pkg::FUNC_ADD_TOKEN;
        else if (sel < 95) rw.tok.func = lgtr_pkg::FUNC_RESAMPLE;
        else rw.tok.func = FUNC_UNUSED;
        return rw;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_topics.size() == 0)
                begin
                    $display("%0t unexpected new_topic expected none actual %0d",
                             $time, m_axis_tdata[3:0]);
                    errors++;
                end
                else if (pending_topics[0] !== m_axis_tdata[3:0])
                begin
                    $display("%0t mismatch new_topic expected %0d actual %0d",
                             $time, pending_topics[0], m_axis_tdata[3:0]);
                    errors++;
                    void'(pending_topics.pop_front());
                end
                else
                begin
                    void'(pending_topics.pop_front());
                end
            end
            m_axis_tready <= !($urandom_range(99) < rx_stall_pct);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        row_t dir_rows [$];
        int i;
        int ph;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // every alpha entry gets written before any resample reads it
        write_regs(16'd0, 13'd4096, 5'd16);
        for (i = 0; i < NTOPIC; i++)
            send_token(mk_row(lgtr_pkg::FUNC_LOAD_ALPHA, 0, 0, i, 0,
                              (i == 0) ? 0 : (i == NTOPIC-1) ? 16'hFFFF
                                                             : $urandom_range(16'hFFFF),
                              0, 0, 0, 0));

        // zero denominators everywhere fall back to the last topic
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_RESAMPLE, 0, 0, 0, 0, 0, 0, 1, 1, 15)};
        dir_rows = {dir_rows, mk_row(FUNC_UNUSED, 1023, 4095, 15, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 1, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_ADD_TOKEN, 1023, 4095, 15, 16'hFFFF,
                                     0, 0, 1, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_RESAMPLE, 1023, 4095, 15, 16'hFFFF,
                                     0, 16'hFFFF, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_LOAD_ALPHA, 0, 0, 3, 0, 16'h0400,
                                     0, 1, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_ADD_TOKEN, 2, 5, 3, 16'h0400, 0, 0,
                                     1, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_RESAMPLE, 2, 5, 3, 16'h0400, 0, 0,
                                     0, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_RESAMPLE, 2, 5, 3, 16'h0400, 0,
                                     16'h8000, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_RESAMPLE, 2, 5, 3, 16'h0400, 0,
                                     16'hFFFF, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_ADD_TOKEN, 2, 5, 7, 16'hFFFF, 0, 0,
                                     1, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_RESAMPLE, 2, 5, 7, 0, 0, 16'h1234,
                                     0, 0, 0)};
        dir_rows = {dir_rows, mk_row(lgtr_pkg::FUNC_RESAMPLE, 1023, 0, 0, 16'hFFFF, 0, 0,
                                     0, 0, 0)};
        foreach (dir_rows[j]) send_token(dir_rows[j]);

        for (ph = 0; ph < 5; ph++)
        begin
            s_axis_tvalid <= 1'b0;
            drain();
            case (ph)
                0: write_regs(16'd10, 13'd1, 5'd1);
                1: write_regs(16'hFFFF, 13'd4096, 5'd5);
                2: write_regs(16'd1000, 13'd100, 5'd16);
                3: write_regs(16'd0, 13'd1, 5'd2);
                default: write_regs(16'd10, 13'd4096, 5'd16);
            endcase
            tx_idle_pct = (ph == 1) ? 45 : (ph == 3) ? 18 : 0;
            rx_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 18 : 0;
            for (i = 0; i < ITEMS_PER_PHASE; i++) send_token(random_row());
        end
        s_axis_tvalid <= 1'b0;
        drain();
        repeat (700) @(posedge clk);
        if (errors == 0 && pending_topics.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
